[rtl/core/rotary_encoder_button_interface_top_defines.svh]
// assertion macros for the rotary encoder and button block
// needs clk and rst visible at the point of use
`ifndef ROTARY_ENCODER_BUTTON_INTERFACE_TOP_DEFINES_SVH
`define ROTARY_ENCODER_BUTTON_INTERFACE_TOP_DEFINES_SVH

// same-cycle implication
`define REB_ASSERT_IMM(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define REB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/reb_pkg.sv]
// shared types, codes and the quadrature table for the encoder/button block
// no dependencies
package reb_pkg;

  localparam logic [1:0] KIND_PIN  = 2'd0;
  localparam logic [1:0] KIND_SNAP = 2'd1;
  localparam logic [1:0] KIND_POLL = 2'd2;

  localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [1:0] CFG_LONG     = 2'd1;
  localparam logic [1:0] CFG_VLONG    = 2'd2;

  localparam logic [15:0] DEBOUNCE_RST = 16'd20;
  localparam logic [15:0] LONG_RST     = 16'd1000;
  localparam logic [15:0] VLONG_RST    = 16'd3000;

  localparam logic [1:0] PINS_RST = 2'b11;

  localparam logic signed [15:0] CNT_MAX = 16'sh7fff;
  localparam logic signed [15:0] CNT_MIN = -16'sh8000;

  // indexed by {previous pins, current pins}
  localparam logic signed [1:0] QUAD_TBL [16] = '{
    2'sd0,  -2'sd1,  2'sd1,  2'sd0,
    2'sd1,   2'sd0,  2'sd0, -2'sd1,
    -2'sd1,  2'sd0,  2'sd0,  2'sd1,
    2'sd0,   2'sd1, -2'sd1,  2'sd0
  };

  typedef enum logic [3:0] {
    OP_PIN  = 4'b0001,
    OP_SNAP = 4'b0010,
    OP_POLL = 4'b0100,
    OP_NOP  = 4'b1000
  } op_t;

  typedef struct packed {
    op_t               op;
    logic signed [1:0] quarter;
    logic [31:0]       now_ms;
    logic              button_raw;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
    logic [15:0] very_long_press_ms;
  } cfg_regs_t;

  typedef struct packed {
    logic signed [1:0]  step;
    logic signed [15:0] snapshot;
    logic               short_press;
    logic               long_press;
    logic               very_long_press;
  } result_t;

endpackage

[rtl/core/reb_if.sv]
// valid/ready channel interfaces: input items, results, register writes
// no dependencies
interface reb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  ab;
  logic [31:0] now_ms;
  logic        button_raw;

  modport source (output valid, kind, ab, now_ms, button_raw, input ready);
  modport sink   (input valid, kind, ab, now_ms, button_raw, output ready);
endinterface

interface reb_out_if;
  logic               valid;
  logic               ready;
  logic signed [1:0]  step;
  logic signed [15:0] snapshot;
  logic               short_press;
  logic               long_press;
  logic               very_long_press;

  modport source (output valid, step, snapshot, short_press, long_press,
                  very_long_press, input ready);
  modport sink   (input valid, step, snapshot, short_press, long_press,
                  very_long_press, output ready);
endinterface

interface reb_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/rotary_encoder_button_interface_top.sv]
// channel     dir  payload
// items       in   kind, ab, now_ms, button_raw
// results     out  step, snapshot, short_press, long_press, very_long_press
// cfg         in   index, data (register write)
//
// one word per clock in both directions; results are registered after the queue
// the front end feeds a QUEUE_DEPTH-entry queue, the back end drains one per clock
// when results stall, the output register then the queue fill and items.ready drops
// rst is synchronous and restores all counters and register defaults
// top level: register file and the front/queue/back chain
// depends on reb_pkg, reb_if, reb_front, reb_queue, reb_back
module rotary_encoder_button_interface_top
  import reb_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2  // 2 to 16
)
(
  input  logic      clk,
  input  logic      rst,
  reb_in_if.sink    items,
  reb_out_if.source results,
  reb_cfg_if.sink   cfg
);

  cfg_regs_t cfg_regs;
  q_status_t qstat;
  item_t     wr_item;
  item_t     head;
  logic      push;
  logic      pop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.debounce_ms        <= DEBOUNCE_RST;
      cfg_regs.long_press_ms      <= LONG_RST;
      cfg_regs.very_long_press_ms <= VLONG_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_DEBOUNCE: cfg_regs.debounce_ms        <= cfg.data;
        CFG_LONG:     cfg_regs.long_press_ms      <= cfg.data;
        CFG_VLONG:    cfg_regs.very_long_press_ms <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  reb_front u_front (
    .clk   (clk),
    .rst   (rst),
    .items (items),
    .qstat (qstat),
    .push  (push),
    .entry (wr_item)
  );

  reb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .head    (head),
    .stat    (qstat)
  );

  reb_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_regs),
    .head    (head),
    .qstat   (qstat),
    .pop     (pop),
    .results (results)
  );

endmodule

[rtl/core/reb_front.sv]
// front end: accepts input words, decodes the kind and runs the quadrature table
// depends on reb_pkg and reb_in_if
module reb_front
  import reb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  reb_in_if.sink      items,
  input  q_status_t   qstat,
  output logic        push,
  output item_t       entry
);

  logic [1:0] prev_pins;
  logic [1:0] prev_pins_next;

  assign items.ready = !qstat.full;
  assign push        = items.valid && items.ready;

  always_comb begin
    entry.now_ms     = items.now_ms;
    entry.button_raw = items.button_raw;
    entry.quarter    = 2'sd0;
    prev_pins_next   = prev_pins;
    unique case (items.kind)
      KIND_PIN: begin
        entry.op       = OP_PIN;
        // diagonal of the table is zero, so unchanged pins add nothing
        entry.quarter  = QUAD_TBL[{prev_pins, items.ab}];
        prev_pins_next = items.ab;
      end
      KIND_SNAP: entry.op = OP_SNAP;
      KIND_POLL: entry.op = OP_POLL;
      default:   entry.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pins <= PINS_RST;
    end else if (push) begin
      prev_pins <= prev_pins_next;
    end
  end

endmodule

[rtl/core/reb_queue.sv]
// small register queue between the front end and the back end
// depends on reb_pkg
module reb_queue
  import reb_pkg::*;
#(
  parameter int DEPTH = 2
)
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  item_t     wr_item,
  input  logic      pop,
  output item_t     head,
  output q_status_t stat
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  item_t         slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head       = slots[rd_ptr];
  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/reb_back.sv]
// back end: detent and pending counters, button debounce, output register
// depends on reb_pkg and reb_out_if
module reb_back
  import reb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_regs_t cfg,
  input  item_t     head,
  input  q_status_t qstat,
  output logic      pop,
  reb_out_if.source results
);

  logic signed [2:0]  quarter_acc, quarter_acc_next;
  logic signed [15:0] detent_count, detent_count_next;
  logic signed [15:0] pending_steps, pending_steps_next;
  logic               stable_level, stable_level_next;
  logic               last_raw, last_raw_next;
  logic [31:0]        raw_change_time, raw_change_time_next;
  logic               is_pressed, is_pressed_next;
  logic [31:0]        press_start_time, press_start_time_next;
  logic               very_long_done, very_long_done_next;

  logic               out_valid;
  result_t            out_res;
  result_t            res;

  assign pop = !qstat.empty && (!out_valid || results.ready);

  always_comb begin
    logic signed [3:0]  acc_sum;
    logic signed [16:0] pend_sum;
    logic [31:0]        deb_diff;
    logic [31:0]        hold_diff;
    logic [31:0]        vlong_diff;

    quarter_acc_next      = quarter_acc;
    detent_count_next     = detent_count;
    pending_steps_next    = pending_steps;
    stable_level_next     = stable_level;
    last_raw_next         = last_raw;
    raw_change_time_next  = raw_change_time;
    is_pressed_next       = is_pressed;
    press_start_time_next = press_start_time;
    very_long_done_next   = very_long_done;
    res                   = '0;
    acc_sum               = {quarter_acc[2], quarter_acc} + {{2{head.quarter[1]}}, head.quarter};
    pend_sum              = {pending_steps[15], pending_steps}
                          + {detent_count[15], detent_count};
    deb_diff              = '0;
    hold_diff             = '0;
    vlong_diff            = '0;

    unique case (head.op)
      OP_PIN: begin
        if (acc_sum == 4'sd4) begin
          quarter_acc_next = 3'sd0;
          if (detent_count != CNT_MAX) detent_count_next = detent_count + 16'sd1;
        end else if (acc_sum == -4'sd4) begin
          quarter_acc_next = 3'sd0;
          if (detent_count != CNT_MIN) detent_count_next = detent_count - 16'sd1;
        end else begin
          quarter_acc_next = acc_sum[2:0];
        end
      end
      OP_SNAP: begin
        res.snapshot      = detent_count;
        detent_count_next = 16'sd0;
        // overflow when the two top bits of the 17-bit sum differ
        if (pend_sum[16] != pend_sum[15]) begin
          pending_steps_next = pend_sum[16] ? CNT_MIN : CNT_MAX;
        end else begin
          pending_steps_next = pend_sum[15:0];
        end
      end
      OP_POLL: begin
        if (pending_steps > 16'sd0) begin
          res.step           = 2'sd1;
          pending_steps_next = pending_steps - 16'sd1;
        end else if (pending_steps < 16'sd0) begin
          res.step           = -2'sd1;
          pending_steps_next = pending_steps + 16'sd1;
        end
        if (head.button_raw != last_raw) begin
          last_raw_next        = head.button_raw;
          raw_change_time_next = head.now_ms;
        end
        deb_diff = head.now_ms - raw_change_time_next;
        if (head.button_raw != stable_level && deb_diff >= {16'd0, cfg.debounce_ms}) begin
          stable_level_next = head.button_raw;
          if (!head.button_raw) begin
            is_pressed_next       = 1'b1;
            press_start_time_next = head.now_ms;
            very_long_done_next   = 1'b0;
          end else begin
            hold_diff = head.now_ms - press_start_time;
            if (is_pressed && !very_long_done) begin
              if (hold_diff >= {16'd0, cfg.long_press_ms}) res.long_press = 1'b1;
              else res.short_press = 1'b1;
            end
            is_pressed_next = 1'b0;
          end
        end
        // uses the start time as updated above, so a fresh press sees zero hold
        vlong_diff = head.now_ms - press_start_time_next;
        if (is_pressed_next && !very_long_done_next &&
            vlong_diff >= {16'd0, cfg.very_long_press_ms}) begin
          res.very_long_press = 1'b1;
          very_long_done_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quarter_acc      <= 3'sd0;
      detent_count     <= 16'sd0;
      pending_steps    <= 16'sd0;
      stable_level     <= 1'b1;
      last_raw         <= 1'b1;
      raw_change_time  <= '0;
      is_pressed       <= 1'b0;
      press_start_time <= '0;
      very_long_done   <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (pop) begin
        quarter_acc      <= quarter_acc_next;
        detent_count     <= detent_count_next;
        pending_steps    <= pending_steps_next;
        stable_level     <= stable_level_next;
        last_raw         <= last_raw_next;
        raw_change_time  <= raw_change_time_next;
        is_pressed       <= is_pressed_next;
        press_start_time <= press_start_time_next;
        very_long_done   <= very_long_done_next;
        out_valid        <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res <= res;
    end
  end

  assign results.valid           = out_valid;
  assign results.step            = out_res.step;
  assign results.snapshot        = out_res.snapshot;
  assign results.short_press     = out_res.short_press;
  assign results.long_press      = out_res.long_press;
  assign results.very_long_press = out_res.very_long_press;

endmodule

[rtl/core/reb_checker.sv]
// port-level checks on the result channel, bound to the top level
// depends on rotary_encoder_button_interface_top_defines.svh
`include "rotary_encoder_button_interface_top_defines.svh"

module reb_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [1:0]  step,
  input logic signed [15:0] snapshot,
  input logic              short_press,
  input logic              long_press,
  input logic              very_long_press
);

  // a stalled word stays valid and holds its step, snapshot and very-long flag
  `REB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(step) && $stable(snapshot) && $stable(very_long_press), "result word changed while stalled")

  // at most one press flag per word
  `REB_ASSERT_IMM(a_press_onehot, out_valid, $onehot0({short_press, long_press, very_long_press}), "more than one press flag")

  // step is only ever -1, 0 or +1
  `REB_ASSERT_IMM(a_step_range, out_valid, step != 2'b10, "step out of range")

  // poll words that carry a step or a press flag never carry a snapshot value
  `REB_ASSERT_IMM(a_poll_no_snap, out_valid && (step != 2'b00 || short_press || long_press || very_long_press), snapshot == 16'sd0, "poll word with snapshot")

endmodule

bind rotary_encoder_button_interface_top reb_checker u_reb_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (results.valid),
  .out_ready       (results.ready),
  .step            (results.step),
  .snapshot        (results.snapshot),
  .short_press     (results.short_press),
  .long_press      (results.long_press),
  .very_long_press (results.very_long_press)
);
